FILE: rtl/scm_pkg.sv
// Shared constants and types for the stream continuity monitor.
// No dependencies.
package scm_pkg;

   localparam int unsigned ROLE_W   = 4;
   localparam int unsigned SEQ_W    = 32;
   localparam int unsigned STAMP_W  = 63;
   localparam int unsigned FRAMES_W = 32;
   localparam int unsigned DRIFT_W  = 64;
   localparam int unsigned THRESH_W = 32;
   localparam int unsigned RATE_W   = 19;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned NSPS_W   = 30;
   localparam int unsigned PROD_W   = FRAMES_W + NSPS_W;
   localparam int unsigned ALU_W    = 64;

   localparam logic [NSPS_W-1:0]   NS_PER_S       = 30'd1000000000;
   localparam logic [THRESH_W-1:0] THRESH_RESET   = 32'd1000000;
   localparam logic [RATE_W-1:0]   RATE_RESET     = 19'd48000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRIFT_THRESHOLD = 1'b0,
      CSR_SAMPLE_RATE     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EVENT_NONE    = 2'd0,
      EVENT_DROPOUT = 2'd1,
      EVENT_DRIFT   = 2'd2,
      EVENT_RESTART = 2'd3
   } event_kind_type;

endpackage

FILE: rtl/stream_continuity_monitor_unit.sv
// Stream continuity monitor: checks audio buffer descriptors for dropouts,
// clock drift and restarts. Depends on scm_pkg.
//
// One transaction in gives one transaction out. Each descriptor passes from
// acceptance to a loaded result through one multiply, then 62 steps of
// a bit-serial restoring divider that shares one 64-bit subtractor with
// the later difference, magnitude and threshold steps; the very first
// descriptor after reset skips all of these steps, and a sample rate of zero
// skips the division. The result sits in an output register, so the next
// descriptor is taken while the previous result waits for rsp_ready.
// Configuration writes take effect at once and belong between transactions.
module stream_continuity_monitor_unit
   import scm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ROLE_W-1:0]           req_role_tag,
   input  logic [SEQ_W-1:0]            req_seq_number,
   input  logic [STAMP_W-1:0]          req_stamp_ns,
   input  logic [FRAMES_W-1:0]         req_frames,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ROLE_W-1:0]           rsp_role_out,
   output logic [1:0]                  rsp_event_kind,
   output logic [SEQ_W-1:0]            rsp_seq_out,
   output logic [STAMP_W-1:0]          rsp_stamp_out,
   output logic [STAMP_W-1:0]          rsp_observed_ns,
   output logic signed [DRIFT_W-1:0]   rsp_drift_ns,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OBS,
      ST_DRIFT,
      ST_MAG,
      ST_CMP,
      ST_DONE
   } state_type;

   localparam logic [5:0] DIV_LAST = 6'(PROD_W - 1);

   state_type             state_ff, state_in;
   logic [THRESH_W-1:0]   thresh_ff, thresh_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic                  have_prior_ff, have_prior_in;
   logic [SEQ_W-1:0]      prior_seq_ff, prior_seq_in;
   logic [STAMP_W-1:0]    prior_stamp_ff, prior_stamp_in;
   logic [FRAMES_W-1:0]   prior_frames_ff, prior_frames_in;
   logic [ROLE_W-1:0]     role_ff, role_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [FRAMES_W-1:0]   frames_ff, frames_in;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0]     rem_ff, rem_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic                  advanced_ff, advanced_in;
   logic [STAMP_W-1:0]    observed_ff, observed_in;
   logic [DRIFT_W-1:0]    drift_ff, drift_in;
   logic [DRIFT_W-1:0]    mag_ff, mag_in;
   logic                  over_ff, over_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ROLE_W-1:0]     out_role_ff, out_role_in;
   event_kind_type        out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0]      out_seq_ff, out_seq_in;
   logic [STAMP_W-1:0]    out_stamp_ff, out_stamp_in;
   logic [STAMP_W-1:0]    out_observed_ff, out_observed_in;
   logic [DRIFT_W-1:0]    out_drift_ff, out_drift_in;

   logic [PROD_W-1:0]     mul_product;
   logic [RATE_W:0]       div_shift;
   logic [ALU_W-1:0]      alu_a, alu_b;
   logic [ALU_W:0]        alu_diff;
   logic                  alu_borrow;
   logic [SEQ_W-1:0]      seq_expect;
   event_kind_type        kind;

   assign mul_product = prior_frames_ff * NS_PER_S;
   assign div_shift   = {rem_ff, quo_ff[PROD_W-1]};
   assign alu_diff    = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow  = alu_diff[ALU_W];
   assign seq_expect  = prior_seq_ff + 32'd1;

   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_DIV: begin
            alu_a = ALU_W'(div_shift);
            alu_b = ALU_W'(rate_ff);
         end
         ST_OBS: begin
            alu_a = {1'b0, stamp_ff};
            alu_b = {1'b0, prior_stamp_ff};
         end
         ST_DRIFT: begin
            alu_a = {1'b0, observed_ff};
            alu_b = ALU_W'(quo_ff);
         end
         ST_MAG: begin
            alu_a = '0;
            alu_b = drift_ff;
         end
         ST_CMP: begin
            alu_a = ALU_W'(thresh_ff);
            alu_b = mag_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      if (!have_prior_ff) begin
         kind = EVENT_NONE;
      end else if (seq_ff != seq_expect) begin
         kind = EVENT_DROPOUT;
      end else if (over_ff) begin
         kind = EVENT_DRIFT;
      end else if (!advanced_ff) begin
         kind = EVENT_RESTART;
      end else begin
         kind = EVENT_NONE;
      end
   end

   always_comb begin
      state_in        = state_ff;
      thresh_in       = thresh_ff;
      rate_in         = rate_ff;
      have_prior_in   = have_prior_ff;
      prior_seq_in    = prior_seq_ff;
      prior_stamp_in  = prior_stamp_ff;
      prior_frames_in = prior_frames_ff;
      role_in         = role_ff;
      seq_in          = seq_ff;
      stamp_in        = stamp_ff;
      frames_in       = frames_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      advanced_in     = advanced_ff;
      observed_in     = observed_ff;
      drift_in        = drift_ff;
      mag_in          = mag_ff;
      over_in         = over_ff;
      out_valid_in    = out_valid_ff;
      out_role_in     = out_role_ff;
      out_kind_in     = out_kind_ff;
      out_seq_in      = out_seq_ff;
      out_stamp_in    = out_stamp_ff;
      out_observed_in = out_observed_ff;
      out_drift_in    = out_drift_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DRIFT_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_SAMPLE_RATE:     rate_in   = csr_wdata[RATE_W-1:0];
            default:             thresh_in = thresh_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               role_in     = req_role_tag;
               seq_in      = req_seq_number;
               stamp_in    = req_stamp_ns;
               frames_in   = req_frames;
               observed_in = '0;
               drift_in    = '0;
               advanced_in = 1'b0;
               over_in     = 1'b0;
               state_in    = have_prior_ff ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            rem_in = '0;
            cnt_in = '0;
            if (rate_ff == '0) begin
               quo_in   = '0;
               state_in = ST_OBS;
            end else begin
               quo_in   = mul_product;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = alu_borrow ? div_shift[RATE_W-1:0] : alu_diff[RATE_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], ~alu_borrow};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_OBS;
            end
         end
         ST_OBS: begin
            advanced_in = !alu_borrow && (alu_diff[ALU_W-1:0] != '0);
            observed_in = advanced_in ? alu_diff[STAMP_W-1:0] : '0;
            state_in    = ST_DRIFT;
         end
         ST_DRIFT: begin
            drift_in = alu_diff[ALU_W-1:0];
            state_in = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = drift_ff[DRIFT_W-1] ? alu_diff[ALU_W-1:0] : drift_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            over_in  = alu_borrow;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in    = 1'b1;
               out_role_in     = role_ff;
               out_kind_in     = kind;
               out_seq_in      = seq_ff;
               out_stamp_in    = stamp_ff;
               out_observed_in = observed_ff;
               out_drift_in    = drift_ff;
               prior_seq_in    = seq_ff;
               prior_stamp_in  = stamp_ff;
               prior_frames_in = frames_ff;
               have_prior_in   = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thresh_ff     <= THRESH_RESET;
         rate_ff       <= RATE_RESET;
         have_prior_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         thresh_ff     <= thresh_in;
         rate_ff       <= rate_in;
         have_prior_ff <= have_prior_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
      prior_seq_ff    <= prior_seq_in;
      prior_stamp_ff  <= prior_stamp_in;
      prior_frames_ff <= prior_frames_in;
      role_ff         <= role_in;
      seq_ff          <= seq_in;
      stamp_ff        <= stamp_in;
      frames_ff       <= frames_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      advanced_ff     <= advanced_in;
      observed_ff     <= observed_in;
      drift_ff        <= drift_in;
      mag_ff          <= mag_in;
      over_ff         <= over_in;
      out_role_ff     <= out_role_in;
      out_kind_ff     <= out_kind_in;
      out_seq_ff      <= out_seq_in;
      out_stamp_ff    <= out_stamp_in;
      out_observed_ff <= out_observed_in;
      out_drift_ff    <= out_drift_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_role_out    = out_role_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_seq_out     = out_seq_ff;
   assign rsp_stamp_out   = out_stamp_ff;
   assign rsp_observed_ns = out_observed_ff;
   assign rsp_drift_ns    = out_drift_ff;

endmodule
